// ----- rtl/pssb_pkg.sv -----
// ----------------------------------------------------------------------------
// Port scan source blocker package
// Shared constants, verdict codes, item and table entry types, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package pssb_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_HDR_END    = 16'd14;
  localparam logic [15:0] IP_HDR_END     = 16'd34;
  localparam logic [15:0] TCP_HDR_END    = 16'd54;

  typedef enum logic [1:0] {
    VERDICT_ABORT = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_PASS  = 2'd2
  } verdict_e;

  // One input request.
  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [31:0] source_address;
    logic [15:0] dest_port;
    logic        syn_flag;
    logic        ack_flag;
  } item_t;

  // One source table entry.
  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] first_port;
    logic [15:0] second_port;
    logic [15:0] third_port;
    logic        blocked;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // One result.
  typedef struct packed {
    verdict_e verdict;
    logic     new_source;
    logic     source_blocked;
  } result_t;

  // Outcome of the header screen.
  typedef struct packed {
    logic     early;
    verdict_e verdict;
  } screen_t;

  // Table memory access from the sequencer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_CREATE,
    ST_UPDATE,
    ST_EMIT
  } state_e;

endpackage

// ----- rtl/pssb_if.sv -----
// ----------------------------------------------------------------------------
// Port scan source blocker channels
// Valid/ready channels for packet requests and verdict results.
// ----------------------------------------------------------------------------
interface pssb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ether_type;
  logic [31:0] source_address;
  logic [15:0] dest_port;
  logic        syn_flag;
  logic        ack_flag;

  modport source (
    output valid, frame_length, ether_type, source_address, dest_port,
           syn_flag, ack_flag,
    input  ready
  );
  modport sink (
    input  valid, frame_length, ether_type, source_address, dest_port,
           syn_flag, ack_flag,
    output ready
  );
endinterface

interface pssb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       new_source;
  logic       source_blocked;

  modport source (
    output valid, verdict, new_source, source_blocked,
    input  ready
  );
  modport sink (
    input  valid, verdict, new_source, source_blocked,
    output ready
  );
endinterface

// ----- rtl/pssb_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module pssb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pssb_screen.sv -----
// ----------------------------------------------------------------------------
// Header screen
// Applies the table-full, length, ethertype, source and port checks in
// order and reports whether a verdict is settled before any table lookup.
// ----------------------------------------------------------------------------
module pssb_screen (
  input  pssb_pkg::item_t   item_i,
  input  logic              full_i,
  output pssb_pkg::screen_t screen_o
);

  import pssb_pkg::*;

  // Checks in priority order; the first that fires decides.
  always_comb begin
    screen_o.early   = 1'b1;
    screen_o.verdict = VERDICT_ABORT;
    priority if (full_i) begin
      screen_o.verdict = VERDICT_PASS;
    end else if (item_i.frame_length < ETH_HDR_END) begin
      screen_o.verdict = VERDICT_ABORT;
    end else if (item_i.ether_type == 16'h0000) begin
      screen_o.verdict = VERDICT_ABORT;
    end else if (item_i.ether_type != ETHERTYPE_IPV4) begin
      screen_o.verdict = VERDICT_PASS;
    end else if (item_i.frame_length < IP_HDR_END) begin
      screen_o.verdict = VERDICT_ABORT;
    end else if (item_i.source_address == 32'h0000_0000) begin
      screen_o.verdict = VERDICT_ABORT;
    end else if (item_i.frame_length < TCP_HDR_END) begin
      screen_o.verdict = VERDICT_ABORT;
    end else if (item_i.dest_port == 16'h0000) begin
      screen_o.verdict = VERDICT_ABORT;
    end else begin
      screen_o.early = 1'b0;
    end
  end

endmodule

// ----- rtl/pssb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lookup sequencer
// Screens each request; if unsettled, scans the source table one entry per
// cycle with a single address comparator, then creates or updates the entry.
// ----------------------------------------------------------------------------
module pssb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pssb_pkg::item_t    item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output pssb_pkg::result_t  res_o,
  output pssb_pkg::ram_req_t ram_req_o,
  input  pssb_pkg::entry_t   rdata_i
);

  import pssb_pkg::*;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  result_t          res_q, res_d;
  screen_t          screen;
  logic [CNT_W-1:0] idx_next;
  logic             scan_last;
  logic             addr_hit;
  logic             port_known;

  pssb_screen u_screen (
    .item_i   (item_q),
    .full_i   (count_q == CNT_W'(TABLE_DEPTH)),
    .screen_o (screen)
  );

  // Shared scan comparator and entry index stepping.
  assign idx_next   = {1'b0, idx_q} + CNT_W'(1);
  assign scan_last  = (idx_next == count_q);
  assign addr_hit   = (rdata_i.source_address == item_q.source_address);
  assign port_known = (rdata_i.first_port == item_q.dest_port) ||
                      (rdata_i.second_port == item_q.dest_port) ||
                      (rdata_i.third_port == item_q.dest_port);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Request, index and result holding registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  // Next state and outputs.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_d       = res_q;
    ram_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = item_i;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (screen.early) begin
          res_d   = '{verdict: screen.verdict, new_source: 1'b0, source_blocked: 1'b0};
          state_d = ST_EMIT;
        end else if (count_q == '0) begin
          state_d = ST_CREATE;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = '0;
          idx_d           = '0;
          state_d         = ST_SCAN;
        end
      end

      // Read data holds entry idx_q; compare and fetch the next one.
      ST_SCAN: begin
        if (addr_hit) begin
          state_d = ST_UPDATE;
        end else if (scan_last) begin
          state_d = ST_CREATE;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_next[IDX_W-1:0];
          idx_d           = idx_next[IDX_W-1:0];
        end
      end

      // Unknown source: the new entry takes the next free slot.
      ST_CREATE: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = count_q[IDX_W-1:0];
        ram_req_o.wdata = '{source_address: item_q.source_address,
                            first_port: item_q.dest_port,
                            second_port: 16'h0000,
                            third_port: 16'h0000,
                            blocked: 1'b0};
        count_d = count_q + CNT_W'(1);
        res_d   = '{verdict: VERDICT_PASS, new_source: 1'b1, source_blocked: 1'b0};
        state_d = ST_EMIT;
      end

      // Known source: check the block mark and record a new port.
      ST_UPDATE: begin
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = rdata_i;
        res_d = '{verdict: VERDICT_PASS, new_source: 1'b0, source_blocked: 1'b0};
        priority if (rdata_i.blocked) begin
          res_d = '{verdict: VERDICT_DROP, new_source: 1'b0, source_blocked: 1'b1};
        end else if (port_known) begin
          res_d.verdict = VERDICT_PASS;
        end else if (rdata_i.second_port == 16'h0000) begin
          ram_req_o.we                = 1'b1;
          ram_req_o.wdata.second_port = item_q.dest_port;
        end else if (rdata_i.third_port == 16'h0000) begin
          ram_req_o.we                = 1'b1;
          ram_req_o.wdata.third_port  = item_q.dest_port;
          ram_req_o.wdata.blocked     = 1'b1;
          res_d = '{verdict: VERDICT_DROP, new_source: 1'b0, source_blocked: 1'b1};
        end else begin
          res_d.verdict = VERDICT_PASS;
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

// ----- rtl/port_scan_source_blocker_unit.sv -----
// ----------------------------------------------------------------------------
// Port scan source blocker
// Flow: a verdict settled by the header checks goes from check to emit and the
//   output register; a lookup first scans the N sources held (up to 1024) and
//   creates or updates an entry. One request at a time; the table scan reads one
//   entry per cycle through the single read port of the source table memory.
// Reset: the sequencer goes idle and the fill count clears, which empties the
//   table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module port_scan_source_blocker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  pssb_in_if.sink     in_i,
  pssb_out_if.source  out_o
);

  import pssb_pkg::*;

  item_t    item;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  ram_req_t ram_req;
  entry_t   rdata;
  logic     out_valid_q, out_valid_d;
  result_t  out_q;

  // Gather the request payload.
  assign item = '{frame_length: in_i.frame_length,
                  ether_type: in_i.ether_type,
                  source_address: in_i.source_address,
                  dest_port: in_i.dest_port,
                  syn_flag: in_i.syn_flag,
                  ack_flag: in_i.ack_flag};

  pssb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .rdata_i     (rdata)
  );

  pssb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.verdict        = out_q.verdict;
  assign out_o.new_source     = out_q.new_source;
  assign out_o.source_blocked = out_q.source_blocked;

  // A created entry always passes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.new_source |-> out_q.verdict == VERDICT_PASS)
    else $error("new source without pass verdict");

  // A blocked source is always dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.source_blocked |-> out_q.verdict == VERDICT_DROP)
    else $error("blocked source not dropped");

  // The sequencer never takes a request while it offers a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && res_valid))
    else $error("request accepted while a result is pending");

  // The table is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> !ram_req.re)
    else $error("table read and write collide");

endmodule

// ----- tb/tb_pssb_checker.sv -----
// ----------------------------------------------------------------------------
// Port scan source blocker checker
// Watches the request and result channels. Every accepted request is run
// through a local copy of the source table to predict its verdict. Every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pssb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pssb_in_if          req_i,
  pssb_out_if         rsp_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  import pssb_pkg::*;

  // Local copy of the source table. Entries at or above the fill count are
  // never read, so only the fill count is cleared at reset.
  logic [31:0] src_addr   [TABLE_DEPTH];
  logic [15:0] src_port_a [TABLE_DEPTH];
  logic [15:0] src_port_b [TABLE_DEPTH];
  logic [15:0] src_port_c [TABLE_DEPTH];
  logic        src_barred [TABLE_DEPTH];
  int unsigned sources_held;

  // Verdicts still owed by the block, oldest first.
  result_t verdicts_due[$];

  initial mismatches_o = 0;

  // Screen the headers, look the source up and update its entry.
  function automatic result_t judge_packet(item_t pkt);
    result_t          res;
    logic [IDX_W-1:0] slot;
    bit               found;

    res = '{verdict: VERDICT_ABORT, new_source: 1'b0, source_blocked: 1'b0};
    found = 1'b0;
    slot = '0;

    // A full table lets everything through without a lookup.
    if (sources_held >= TABLE_DEPTH) begin
      res.verdict = VERDICT_PASS;
      return res;
    end
    if (pkt.frame_length < ETH_HDR_END || pkt.ether_type == 16'd0) return res;
    if (pkt.ether_type != ETHERTYPE_IPV4) begin
      res.verdict = VERDICT_PASS;
      return res;
    end
    if (pkt.frame_length < IP_HDR_END || pkt.source_address == 32'd0) return res;
    if (pkt.frame_length < TCP_HDR_END || pkt.dest_port == 16'd0) return res;

    for (int unsigned i = 0; i < sources_held; i++) begin
      if (!found && src_addr[IDX_W'(i)] == pkt.source_address) begin
        slot = IDX_W'(i);
        found = 1'b1;
      end
    end

    // An unknown source takes the next free entry with its first port.
    if (!found) begin
      slot = IDX_W'(sources_held);
      src_addr[slot]   = pkt.source_address;
      src_port_a[slot] = pkt.dest_port;
      src_port_b[slot] = 16'd0;
      src_port_c[slot] = 16'd0;
      src_barred[slot] = 1'b0;
      sources_held++;
      res.new_source = 1'b1;
    end

    if (src_barred[slot]) begin
      res.verdict = VERDICT_DROP;
      res.source_blocked = 1'b1;
      return res;
    end

    res.verdict = VERDICT_PASS;
    if (src_port_a[slot] == pkt.dest_port || src_port_b[slot] == pkt.dest_port ||
        src_port_c[slot] == pkt.dest_port) begin
      // Port already seen from this source.
    end else if (src_port_b[slot] == 16'd0) begin
      src_port_b[slot] = pkt.dest_port;
    end else if (src_port_c[slot] == 16'd0) begin
      // The third distinct port marks the source as a scanner.
      src_port_c[slot] = pkt.dest_port;
      src_barred[slot] = 1'b1;
      res.verdict = VERDICT_DROP;
      res.source_blocked = 1'b1;
    end
    return res;
  endfunction

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: result %s is %0d, expected %0d", $time, what, got, want);
    mismatches_o++;
  endtask

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    item_t   pkt;
    result_t want;

    if (!rst_ni) begin
      sources_held = 0;
      verdicts_due.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        pkt.frame_length   = req_i.frame_length;
        pkt.ether_type     = req_i.ether_type;
        pkt.source_address = req_i.source_address;
        pkt.dest_port      = req_i.dest_port;
        pkt.syn_flag       = req_i.syn_flag;
        pkt.ack_flag       = req_i.ack_flag;
        verdicts_due.push_back(judge_packet(pkt));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("with nothing outstanding, verdict", 32'(rsp_i.verdict), 0);
        end else begin
          want = verdicts_due.pop_front();
          if (rsp_i.verdict !== want.verdict)
            report_mismatch("verdict", 32'(rsp_i.verdict), 32'(want.verdict));
          if (rsp_i.new_source !== want.new_source)
            report_mismatch("new_source", 32'(rsp_i.new_source), 32'(want.new_source));
          if (rsp_i.source_blocked !== want.source_blocked)
            report_mismatch("source_blocked", 32'(rsp_i.source_blocked),
                            32'(want.source_blocked));
        end
      end
    end
    pending_o = verdicts_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Port scan source blocker testbench
// Drives directed and random packet requests with random gaps on both sides
// and one long hold-off on the result side. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import pssb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 556;
  localparam int unsigned POOL_SIZE    = 8;
  localparam int unsigned POOL_W       = $clog2(POOL_SIZE);

  logic clk;
  logic rst_n;

  pssb_in_if  req_if ();
  pssb_out_if rsp_if ();

  int unsigned mismatches;
  int unsigned pending;

  logic [31:0] src_pool [POOL_SIZE];
  bit          send_calm;
  bit          take_calm;

  port_scan_source_blocker_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  tb_pssb_checker checker_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before the next request or result; calm stretches have none.
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [31:0] fresh_address();
    logic [31:0] addr;
    do addr = $urandom; while (addr == 32'd0);
    return addr;
  endfunction

  function automatic item_t make_pkt(logic [15:0] flen, logic [15:0] etype,
                                     logic [31:0] saddr, logic [15:0] port,
                                     logic syn, logic ack);
    item_t pkt;
    pkt.frame_length   = flen;
    pkt.ether_type     = etype;
    pkt.source_address = saddr;
    pkt.dest_port      = port;
    pkt.syn_flag       = syn;
    pkt.ack_flag       = ack;
    return pkt;
  endfunction

  // Mostly well-formed TCP from a small set of sources with few ports, so
  // that sources walk through their second and third port; the rest is
  // fresh sources and malformed headers.
  function automatic item_t random_packet();
    item_t       pkt;
    int unsigned kind;
    logic [15:0] flen;

    kind = $urandom_range(0, 99);
    flen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(54, 65535))
                                       : 16'($urandom_range(54, 1514));
    if ($urandom_range(0, 11) == 0)
      src_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))] = fresh_address();
    pkt = make_pkt(flen, ETHERTYPE_IPV4, src_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))],
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                               : 16'($urandom_range(1, 5)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (kind >= 70 && kind < 80) begin
      pkt.source_address = fresh_address();
    end else if (kind >= 80) begin
      pkt.frame_length = $urandom_range(0, 1) ? 16'($urandom_range(0, 60))
                                              : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0:       pkt.ether_type = 16'd0;
        1:       pkt.ether_type = 16'($urandom_range(0, 65535));
        default: pkt.ether_type = ETHERTYPE_IPV4;
      endcase
      case ($urandom_range(0, 2))
        0:       pkt.source_address = 32'd0;
        1:       pkt.source_address = $urandom;
        default: ;
      endcase
      if ($urandom_range(0, 1)) pkt.dest_port = 16'd0;
      else pkt.dest_port = 16'($urandom_range(0, 65535));
    end
    return pkt;
  endfunction

  // Offer one request from a falling edge and return at the falling edge
  // after it was taken. The caller either offers the next one at once or
  // drops valid, so valid is assigned once per step.
  task automatic send_request(item_t pkt);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.frame_length   <= pkt.frame_length;
    req_if.ether_type     <= pkt.ether_type;
    req_if.source_address <= pkt.source_address;
    req_if.dest_port      <= pkt.dest_port;
    req_if.syn_flag       <= pkt.syn_flag;
    req_if.ack_flag       <= pkt.ack_flag;
    req_if.valid          <= 1'b1;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    @(negedge clk);
  endtask

  // Result side: random ready gaps, and one long hold-off early in the run
  // so that the block backs up and stalls its request side.
  initial begin
    int unsigned gap;
    int unsigned taken;
    rsp_if.ready = 1'b0;
    taken = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = (taken == 60) ? 400 : draw_gap(take_calm);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [31:0] src_a;
    logic [31:0] src_b;

    req_if.valid          = 1'b0;
    req_if.frame_length   = '0;
    req_if.ether_type     = '0;
    req_if.source_address = '0;
    req_if.dest_port      = '0;
    req_if.syn_flag       = 1'b0;
    req_if.ack_flag       = 1'b0;
    send_calm = 1'b0;
    take_calm = 1'b0;
    foreach (src_pool[i]) src_pool[i] = fresh_address();
    src_a = 32'h0A00_0001;
    src_b = 32'hFFFF_FFFF;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Header bounds, zero fields and the non-IPv4 path.
    send_request(make_pkt(16'd0, ETHERTYPE_IPV4, src_a, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'd13, ETHERTYPE_IPV4, src_a, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'd14, 16'd0, src_a, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'hFFFF, 16'h86DD, src_a, 16'd80, 1'b0, 1'b0));
    send_request(make_pkt(16'd14, 16'hFFFF, src_a, 16'd80, 1'b0, 1'b1));
    send_request(make_pkt(16'd33, ETHERTYPE_IPV4, src_a, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'd34, ETHERTYPE_IPV4, 32'd0, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'hFFFF, ETHERTYPE_IPV4, 32'd0, 16'd80, 1'b1, 1'b1));
    send_request(make_pkt(16'd53, ETHERTYPE_IPV4, src_a, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'd54, ETHERTYPE_IPV4, src_a, 16'd0, 1'b1, 1'b0));

    // One source walks from new through known and second port to blocked.
    send_request(make_pkt(16'd54, ETHERTYPE_IPV4, src_a, 16'd80, 1'b1, 1'b0));
    send_request(make_pkt(16'd60, ETHERTYPE_IPV4, src_a, 16'd80, 1'b0, 1'b1));
    send_request(make_pkt(16'd60, ETHERTYPE_IPV4, src_a, 16'd443, 1'b1, 1'b0));
    send_request(make_pkt(16'd60, ETHERTYPE_IPV4, src_a, 16'd443, 1'b1, 1'b1));
    send_request(make_pkt(16'd60, ETHERTYPE_IPV4, src_a, 16'd22, 1'b1, 1'b0));
    send_request(make_pkt(16'd60, ETHERTYPE_IPV4, src_a, 16'd80, 1'b0, 1'b1));
    send_request(make_pkt(16'd60, ETHERTYPE_IPV4, src_a, 16'd0, 1'b1, 1'b0));

    // Extreme address and port values.
    send_request(make_pkt(16'hFFFF, ETHERTYPE_IPV4, src_b, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_pkt(16'hFFFF, ETHERTYPE_IPV4, src_b, 16'd1, 1'b0, 1'b0));
    send_request(make_pkt(16'hFFFF, ETHERTYPE_IPV4, src_b, 16'hFFFF, 1'b1, 1'b0));
    send_request(make_pkt(16'hFFFF, ETHERTYPE_IPV4, src_b, 16'd2, 1'b0, 1'b1));
    send_request(make_pkt(16'd54, ETHERTYPE_IPV4, src_b, 16'd3, 1'b1, 1'b0));

    repeat (RANDOM_ITEMS) send_request(random_packet());
    send_request(make_pkt(16'd0, 16'd0, 32'd0, 16'd0, 1'b0, 1'b0));
    req_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TABLE_DEPTH + 20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
